// ===== rtl/core/wswr_pkg.sv =====
// ----------------------------------------------------------------------------
// wswr_pkg
// Shared types and constants for the weighted sampling core.
// ----------------------------------------------------------------------------
`default_nettype none

package wswr_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = WEIGHT_W + IDX_W;
  localparam int RND_W    = 31;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int DCNT_W   = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_START  = 2'd2,
    ACT_PICK   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ITEM  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_WRD,
    S_WCHK,
    S_LRD,
    S_LCHK,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/wswr_if.sv =====
// ----------------------------------------------------------------------------
// wswr channel interfaces
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface wswr_in_if;
  logic                           valid;
  logic                           ready;
  logic [wswr_pkg::ACT_W-1:0]     action;
  logic [wswr_pkg::VALUE_W-1:0]   entry_value;
  logic [wswr_pkg::WEIGHT_W-1:0]  entry_weight;
  logic [wswr_pkg::DCNT_W-1:0]    draw_count;
  logic [wswr_pkg::RND_W-1:0]     random_word;

  modport source (output valid, action, entry_value, entry_weight, draw_count,
                  random_word, input ready);
  modport sink   (input valid, action, entry_value, entry_weight, draw_count,
                  random_word, output ready);
endinterface

interface wswr_out_if;
  logic                          valid;
  logic                          ready;
  logic [wswr_pkg::VALUE_W-1:0]  picked_value;
  logic [wswr_pkg::STAT_W-1:0]   status;
  logic                          last;

  modport source (output valid, picked_value, status, last, input ready);
  modport sink   (input valid, picked_value, status, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wswr_moddiv.sv =====
// ----------------------------------------------------------------------------
// wswr_moddiv
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wswr_moddiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wswr_pkg::RND_W-1:0]    dividend,
  input  logic [wswr_pkg::TOTAL_W-1:0]  divisor,
  output logic                          done,
  output logic [wswr_pkg::TOTAL_W-1:0]  remainder
);
  import wswr_pkg::*;

  localparam int STEP_W = $clog2(RND_W);

  logic               busy_r, busy_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [RND_W-1:0]   dvd_r, dvd_nxt;
  logic [TOTAL_W-1:0] rem_r, rem_nxt;
  logic [TOTAL_W-1:0] div_r, div_nxt;
  logic [TOTAL_W:0]   trial;
  logic               done_r, done_nxt;

  // shift in the next bit and subtract where it fits
  always_comb begin
    trial    = {rem_r, dvd_r[RND_W-1]};
    busy_nxt = busy_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = TOTAL_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = TOTAL_W'(trial);
      end
      dvd_nxt  = {dvd_r[RND_W-2:0], 1'b0};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(RND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

  // remainder stays below the divisor once finished
  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (rem_r < div_r)) else $error("remainder not reduced");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(busy_r)) else $error("done without a run");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("start while busy");

endmodule

`default_nettype wire

// ===== rtl/core/weighted_sample_without_replacement_core.sv =====
// ----------------------------------------------------------------------------
// weighted_sample_without_replacement_core
// Weighted sampling without replacement over a table of up to 64 entries.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  in_ch   | in  | valid / ready   | action, entry_value, entry_weight,
//          |     |                 | draw_count, random_word
//  out_ch  | out | valid / ready   | picked_value, status, last
//
//  Clear, append and arming start are handled in the idle state; a result
//  passes through the emit state. A pick waits on the remainder unit for
//  the reduced random value, then walks the table through the registered
//  store read port, with a read state and a check state for each entry.
//  A listing start steps through read, latch and emit states per entry.
//  Reset clears all control state and the taken marks at once.
//  Results sit in an output register; a stalled sink holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_sample_without_replacement_core (
  input  logic        clk,
  input  logic        rst_n,
  wswr_in_if.sink     in_ch,
  wswr_out_if.source  out_ch
);
  import wswr_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOTAL_W-1:0]  full_r, full_nxt;
  logic [TOTAL_W-1:0]  remain_r, remain_nxt;
  logic [DCNT_W-1:0]   draws_r, draws_nxt;
  logic [DEPTH-1:0]    taken_r, taken_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [TOTAL_W-1:0]  rval_r, rval_nxt;
  logic                list_r, list_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                res_last_r, res_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic [VALUE_W-1:0]  value_mem [DEPTH];
  logic [WEIGHT_W-1:0] weight_mem [DEPTH];
  logic [VALUE_W-1:0]  rd_value_r;
  logic [WEIGHT_W-1:0] rd_weight_r;
  logic                mem_we;

  logic                mod_start;
  logic                mod_done;
  logic [TOTAL_W-1:0]  mod_rem;
  logic                slot_free;

  wswr_moddiv u_moddiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_ch.random_word),
    .divisor   (remain_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign slot_free = !out_valid_r || out_ch.ready;

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    full_nxt       = full_r;
    remain_nxt     = remain_r;
    draws_nxt      = draws_r;
    taken_nxt      = taken_r;
    idx_nxt        = idx_r;
    rval_nxt       = rval_r;
    list_nxt       = list_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mod_start      = 1'b0;
    in_ch.ready    = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (action_t'(in_ch.action))
            ACT_CLEAR: begin
              taken_nxt  = '0;
              count_nxt  = '0;
              full_nxt   = '0;
              remain_nxt = '0;
              draws_nxt  = '0;
            end
            ACT_APPEND: begin
              draws_nxt = '0;
              if (count_r == CNT_W'(DEPTH)) begin
                res_value_nxt  = '0;
                res_status_nxt = ST_ERROR;
                res_last_nxt   = 1'b1;
                list_nxt       = 1'b0;
                state_nxt      = S_EMIT;
              end else begin
                mem_we                        = 1'b1;
                taken_nxt[count_r[IDX_W-1:0]] = 1'b0;
                count_nxt                     = count_r + CNT_W'(1);
                full_nxt = full_r + TOTAL_W'(in_ch.entry_weight);
              end
            end
            ACT_START: begin
              draws_nxt = '0;
              if (in_ch.draw_count == '0 || count_r == '0) begin
                res_value_nxt  = '0;
                res_status_nxt = ST_EMPTY;
                res_last_nxt   = 1'b1;
                list_nxt       = 1'b0;
                state_nxt      = S_EMIT;
              end else if (in_ch.draw_count >= DCNT_W'(count_r)) begin
                idx_nxt   = '0;
                list_nxt  = 1'b1;
                state_nxt = S_LRD;
              end else begin
                taken_nxt  = '0;
                remain_nxt = full_r;
                draws_nxt  = in_ch.draw_count;
              end
            end
            ACT_PICK: begin
              list_nxt = 1'b0;
              if (draws_r == '0 || remain_r == '0) begin
                draws_nxt      = '0;
                res_value_nxt  = '0;
                res_status_nxt = ST_ERROR;
                res_last_nxt   = 1'b1;
                state_nxt      = S_EMIT;
              end else begin
                mod_start = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      // wait for the reduced random value
      S_MOD: begin
        if (mod_done) begin
          rval_nxt  = mod_rem;
          state_nxt = S_WRD;
        end
      end
      // store read issued at idx; end of table means totals went astray
      S_WRD: begin
        if (idx_r == count_r) begin
          draws_nxt      = '0;
          res_value_nxt  = '0;
          res_status_nxt = ST_ERROR;
          res_last_nxt   = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_WCHK;
        end
      end
      // skip taken entries, select where the value falls inside the weight
      S_WCHK: begin
        if (taken_r[idx_r[IDX_W-1:0]]) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_WRD;
        end else if (rval_r < TOTAL_W'(rd_weight_r)) begin
          taken_nxt[idx_r[IDX_W-1:0]] = 1'b1;
          remain_nxt     = remain_r - TOTAL_W'(rd_weight_r);
          draws_nxt      = draws_r - DCNT_W'(1);
          res_value_nxt  = rd_value_r;
          res_status_nxt = ST_ITEM;
          res_last_nxt   = (draws_r == DCNT_W'(1));
          state_nxt      = S_EMIT;
        end else begin
          rval_nxt  = rval_r - TOTAL_W'(rd_weight_r);
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_WRD;
        end
      end
      S_LRD: begin
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        res_value_nxt  = rd_value_r;
        res_status_nxt = ST_ITEM;
        res_last_nxt   = (idx_r + CNT_W'(1) == count_r);
        state_nxt      = S_EMIT;
      end
      // hand the result to the output register once it is free
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          if (list_r && !res_last_r) begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_LRD;
          end else begin
            list_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      full_r      <= '0;
      remain_r    <= '0;
      draws_r     <= '0;
      taken_r     <= '0;
      list_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      remain_r    <= remain_nxt;
      draws_r     <= draws_nxt;
      taken_r     <= taken_nxt;
      list_r      <= list_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    rval_r       <= rval_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // entry stores: write on append, registered read at the walk index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[count_r[IDX_W-1:0]]  <= in_ch.entry_value;
      weight_mem[count_r[IDX_W-1:0]] <= in_ch.entry_weight;
    end
    rd_value_r  <= value_mem[idx_r[IDX_W-1:0]];
    rd_weight_r <= weight_mem[idx_r[IDX_W-1:0]];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.picked_value = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.last         = out_last_r;

  a_remain_le_full: assert property (@(posedge clk) disable iff (!rst_n)
    remain_r <= full_r) else $error("remaining weight above full total");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("entry count overflow");
  a_mod_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_MOD) else $error("remainder outside pick");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("result dropped");

endmodule

`default_nettype wire
